// ----- src/lsts_pkg.sv -----
package lsts_pkg;

    localparam int DIM_MAX     = 1024;
    localparam int K_MAX       = 16;
    localparam int CENT_DEPTH  = 256;
    localparam int LANES       = 8;
    localparam int GROUPS      = (DIM_MAX + LANES - 1) / LANES;
    localparam int GP_W        = $clog2(GROUPS);
    localparam int DIM_W       = $clog2(DIM_MAX);
    localparam int ACC_W       = 48;
    localparam int SCORE_W     = 64;
    localparam int ID_W        = 16;
    localparam int KCNT_W      = $clog2(K_MAX + 1);
    localparam int KIDX_W      = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    typedef enum logic [1:0] {
        KIND_CENT   = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_GROUP  = 2'd2,
        KIND_FINISH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_BITS = 2'd0,
        CFG_DIM  = 2'd1,
        CFG_TOPK = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DOT,
        ST_SCORE,
        ST_DRAIN
    } state_t;

    // offer broadcast to the cell row
    typedef struct packed {
        logic                      ins;
        logic signed [SCORE_W-1:0] score;
        logic [ID_W-1:0]           id;
    } offer_t;

endpackage

// ----- src/lsts_cell.sv -----
module lsts_cell
    import lsts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  offer_t                    offer,
    input  logic                      clr,
    input  logic                      shift,
    input  logic                      prev_valid,
    input  logic signed [SCORE_W-1:0] prev_score,
    input  logic [ID_W-1:0]           prev_id,
    input  logic                      prev_take,
    input  logic                      next_pad_valid,
    input  logic signed [SCORE_W-1:0] next_score,
    input  logic [ID_W-1:0]           next_id,
    output logic                      take,
    output logic                      valid,
    output logic signed [SCORE_W-1:0] score,
    output logic [ID_W-1:0]           id
);

    logic                      valid_reg, valid_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic [ID_W-1:0]           id_reg, id_next;

    // new entry goes before this cell's entry if strictly greater or cell empty
    assign take = !valid_reg || (offer.score > score_reg);

    // prev_valid is tied high on the first cell
    always_comb
    begin
        valid_next = valid_reg;
        score_next = score_reg;
        id_next    = id_reg;
        if (clr)
        begin
            valid_next = 1'b0;
        end
        else if (shift)
        begin
            valid_next = next_pad_valid;
            score_next = next_score;
            id_next    = next_id;
        end
        else if (offer.ins && take && prev_valid)
        begin
            valid_next = 1'b1;
            if (prev_take)
            begin
                score_next = prev_score;
                id_next    = prev_id;
            end
            else
            begin
                score_next = offer.score;
                id_next    = offer.id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        id_reg    <= id_next;
    end

    assign valid = valid_reg;
    assign score = score_reg;
    assign id    = id_reg;

endmodule

// ----- src/lsts_dot.sv -----
module lsts_dot
    import lsts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_cent,
    input  logic                    wr_query,
    input  logic [9:0]              wr_index,
    input  logic signed [15:0]      wr_value,
    input  logic                    rd_en,
    input  logic [63:0]             planes,
    input  logic [3:0]              bits_per_code,
    input  logic [10:0]             dim_in_use,
    input  logic [GP_W-1:0]         group_pos,
    input  logic                    acc_en,
    input  logic                    acc_clr,
    output logic signed [ACC_W-1:0] dot
);

    logic signed [15:0] cent_mem [LANES][CENT_DEPTH];
    logic signed [15:0] query_mem [LANES][GROUPS];

    logic signed [15:0] cent_q [LANES];
    logic signed [15:0] query_q [LANES];
    logic [LANES-1:0]   live_reg;
    logic signed [31:0] prod_reg [LANES];
    logic [LANES-1:0]   live2_reg;
    logic               mul_en_reg, add_en_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic [3:0]  nb;
    logic [11:0] dim_c;
    logic [7:0]  code [LANES];
    logic [LANES-1:0] live;

    assign nb    = (bits_per_code > 4'd8) ? 4'd8 : bits_per_code;
    assign dim_c = (dim_in_use > 11'(DIM_MAX)) ? 12'(DIM_MAX) : {1'b0, dim_in_use};

    always_comb
    begin
        for (int b = 0; b < LANES; b++)
        begin
            code[b] = '0;
            for (int p = 0; p < 8; p++)
            begin
                if (p < nb)
                begin
                    code[b][p] = planes[8 * p + 7 - b];
                end
            end
            live[b] = ({2'b00, group_pos, 3'(b)} < dim_c);
        end
    end

    // each lane owns every eighth query dimension and a copy of the centroids
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (wr_cent && wr_index < 10'(CENT_DEPTH))
            begin
                cent_mem[g][wr_index[7:0]] <= wr_value;
            end
            if (wr_query && wr_index[2:0] == 3'(g))
            begin
                query_mem[g][wr_index[DIM_W-1:3]] <= wr_value;
            end
            cent_q[g]  <= cent_mem[g][code[g]];
            query_q[g] <= query_mem[g][group_pos];
            prod_reg[g] <= query_q[g] * cent_q[g];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        for (int b = 0; b < LANES; b++)
        begin
            if (live2_reg[b])
            begin
                acc_next = acc_next + ACC_W'(prod_reg[b]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg   <= '0;
            live2_reg  <= '0;
            mul_en_reg <= 1'b0;
            add_en_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            live_reg   <= rd_en ? live : '0;
            mul_en_reg <= rd_en;
            live2_reg  <= mul_en_reg ? live_reg : '0;
            add_en_reg <= mul_en_reg;
            if (acc_clr)
            begin
                acc_reg <= '0;
            end
            else if (acc_en && add_en_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign dot = acc_reg;

endmodule

// ----- src/lut_score_top_k_search_core.sv -----
// Kinds 0/1 and a non-last byte group are accepted without holding off the input.
// A last byte group stalls input for read, multiply, accumulate, norm multiply and insert.
// Finish: keff results leave the cell row, one result per cycle while m_tready is high.
// Throughput: one byte group per cycle within a vector, set by the 3-stage lane pipe
// draining at vector end. Reset clears control state and the held list;
// centroid and query memories are undefined until written.
module lut_score_top_k_search_core
    import lsts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // index[9:0], value[25:10], planes[89:26], norm[105:90]
    input  logic [1:0]   s_tuser,  // kind
    input  logic         s_tlast,  // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,  // score[63:0], vector_id[80:64]
    output logic         m_tlast,  // last_result
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_data
);
    // s_tdata fields from bit 0: index(10), value(16), planes(64), norm(16)

    state_t state_reg, state_next;
    logic [3:0]  bits_reg;
    logic [10:0] dim_reg;
    logic [4:0]  topk_reg;
    logic [GP_W-1:0] gpos_reg;
    logic [ID_W-1:0] vcnt_reg;
    logic [15:0] norm_reg;
    logic [2:0]  wait_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [KCNT_W-1:0] out_cnt_reg;
    logic [KCNT_W-1:0] keff;

    kind_t kind;
    logic  acc_in;
    logic  is_last;
    logic  signed [ACC_W-1:0] dot;
    offer_t offer;
    logic  clr, shift;

    logic                      c_valid [K_MAX];
    logic signed [SCORE_W-1:0] c_score [K_MAX];
    logic [ID_W-1:0]           c_id    [K_MAX];
    logic                      c_take  [K_MAX];

    assign kind    = kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_RUN);
    assign acc_in  = s_tvalid && s_tready;
    assign is_last = acc_in && kind == KIND_GROUP && s_tlast;
    assign keff    = (topk_reg == 5'd0) ? KCNT_W'(1)
                   : (topk_reg > 5'(K_MAX)) ? KCNT_W'(K_MAX) : KCNT_W'(topk_reg);

    lsts_dot u_dot (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_cent       (acc_in && kind == KIND_CENT),
        .wr_query      (acc_in && kind == KIND_QUERY),
        .wr_index      (s_tdata[9:0]),
        .wr_value      (s_tdata[25:10]),
        .rd_en         (acc_in && kind == KIND_GROUP),
        .planes        (s_tdata[89:26]),
        .bits_per_code (bits_reg),
        .dim_in_use    (dim_reg),
        .group_pos     (gpos_reg),
        .acc_en        (1'b1),
        .acc_clr       (clr || (state_reg == ST_SCORE)),
        .dot           (dot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (is_last)
                begin
                    state_next = ST_DOT;
                end
                else if (acc_in && kind == KIND_FINISH)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DOT:
            begin
                if (wait_reg == 3'd0)
                begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                state_next = ST_RUN;
            end
            ST_DRAIN:
            begin
                if (m_tready && out_cnt_reg == keff - KCNT_W'(1))
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        offer.ins   = (state_reg == ST_SCORE);
        offer.score = score_reg;
        offer.id    = vcnt_reg;
        shift       = (state_reg == ST_DRAIN) && m_tready;
        clr         = (state_reg == ST_DRAIN) && m_tready
                      && out_cnt_reg == keff - KCNT_W'(1);
    end

    for (genvar i = 0; i < K_MAX; i++)
    begin : g_cell
        logic                      pv;
        logic signed [SCORE_W-1:0] ps;
        logic [ID_W-1:0]           pi;
        logic                      pt;
        logic                      nv;
        logic signed [SCORE_W-1:0] ns;
        logic [ID_W-1:0]           ni;
        if (i == 0)
        begin : g_first
            assign pv = 1'b1;
            assign ps = '0;
            assign pi = '0;
            assign pt = 1'b0;
        end
        else
        begin : g_mid
            assign pv = c_valid[i-1];
            assign ps = c_score[i-1];
            assign pi = c_id[i-1];
            assign pt = c_take[i-1];
        end
        if (i == K_MAX - 1)
        begin : g_end
            assign nv = 1'b0;
            assign ns = '0;
            assign ni = '0;
        end
        else
        begin : g_nxt
            assign nv = c_valid[i+1];
            assign ns = c_score[i+1];
            assign ni = c_id[i+1];
        end
        // empty entries beyond the effective k are never inserted into
        lsts_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .offer          ('{ins: offer.ins && (KCNT_W'(i) < keff || c_valid[i]),
                               score: offer.score, id: offer.id}),
            .clr            (clr),
            .shift          (shift),
            .prev_valid     (pv),
            .prev_score     (ps),
            .prev_id        (pi),
            .prev_take      (pt),
            .next_pad_valid (nv),
            .next_score     (ns),
            .next_id        (ni),
            .take           (c_take[i]),
            .valid          (c_valid[i]),
            .score          (c_score[i]),
            .id             (c_id[i])
        );
    end

    assign m_tvalid = (state_reg == ST_DRAIN);
    assign m_tdata  = {7'd0,
                       c_valid[0] ? {1'b0, c_id[0]} : 17'h1FFFF,
                       c_valid[0] ? c_score[0] : {1'b1, 63'd0}};
    assign m_tlast  = (out_cnt_reg == keff - KCNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            bits_reg    <= 4'd4;
            dim_reg     <= 11'd128;
            topk_reg    <= 5'd10;
            gpos_reg    <= '0;
            vcnt_reg    <= '0;
            wait_reg    <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BITS: bits_reg <= cfg_data[3:0];
                    CFG_DIM:  dim_reg  <= cfg_data;
                    CFG_TOPK: topk_reg <= cfg_data[4:0];
                    default:  ;
                endcase
            end
            if (acc_in && kind == KIND_GROUP)
            begin
                gpos_reg <= s_tlast ? '0
                          : (gpos_reg == GP_W'(GROUPS - 1)) ? '0 : gpos_reg + GP_W'(1);
            end
            if (is_last)
            begin
                wait_reg <= 3'd2;
            end
            else if (state_reg == ST_DOT)
            begin
                wait_reg <= wait_reg - 3'd1;
            end
            if (state_reg == ST_SCORE)
            begin
                vcnt_reg <= vcnt_reg + ID_W'(1);
            end
            if (acc_in && kind == KIND_FINISH)
            begin
                gpos_reg <= '0;
                vcnt_reg <= '0;
                out_cnt_reg <= '0;
            end
            else if (shift)
            begin
                out_cnt_reg <= out_cnt_reg + KCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_last)
        begin
            norm_reg <= s_tdata[105:90];
        end
        if (state_reg == ST_DOT && wait_reg == 3'd0)
        begin
            score_reg <= SCORE_W'(dot) * $signed({1'b0, norm_reg});
        end
    end

endmodule
